### hdl/rtmd_pkg.sv
// Shared widths, codes and state type for the ramped timed motor drive.
`timescale 1ns / 1ps

package rtmd_pkg;

  // Fixed field widths
  localparam int DIR_W    = 2;
  localparam int ONTIME_W = 25;
  localparam int RAMP_W   = 16;
  localparam int LEVEL_W  = 10;

  // Behavior constants
  localparam int DUTY_MAX  = 1023;
  localparam int TIME_BITS = 24;

  // Ramp product: elapsed below the ramp length times the target level
  localparam int PROD_W = RAMP_W + LEVEL_W;

  // Serial step counters
  localparam int MUL_CNT_W = $clog2(LEVEL_W);
  localparam int DIV_CNT_W = $clog2(PROD_W);

  // Packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // Item kinds and direction codes
  localparam logic       KIND_TICK = 1'b0;
  localparam logic       KIND_CMD  = 1'b1;
  localparam logic [1:0] DIR_FWD   = 2'd1;
  localparam logic [1:0] DIR_REV   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } rtmd_state_t;

endpackage

### hdl/ramped_timed_motor_drive.sv
// Top level of the ramped timed H-bridge drive.
`timescale 1ns / 1ps
//
// Input stream: one item is either a millisecond tick (tuser 0) or a motor
// command (tuser 1) carrying direction, on-time, ramp time and speed level.
// Output stream: one item per input item with duty, both bridge lines,
// the running flag and the timed-stop flag of that input.
//
// Commands, stopped ticks, ticks that end a timed run and ticks past the end
// of the ramp settle at once: after acceptance the item passes the done
// state, and its result enters the output register once that register is free;
// the next item is taken only after the return to idle. A tick inside the
// ramp computes elapsed * speed / ramp with a bit-serial multiplier and a
// restoring divider, passing the multiply, divide and done states in turn
// before its result is loaded and the next item is taken.
//
// Reset clears all drive state: motor stopped, duty 0, both lines low, and
// the output register empty. The result sits in an output register; a new
// item is accepted while it waits, but the next result is held back until
// the receiver takes the pending one.

module ramped_timed_motor_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // direction[1:0], on_time_ms[26:2], ramp_ms[42:27], speed_level[52:43]
  input  logic [rtmd_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // duty[9:0], drive_a[10], drive_b[11], running[12], timed_stop[13]
  output logic [rtmd_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import rtmd_pkg::*;

  localparam logic [32:0] TIME_MAX_W = (33'd1 << TIME_BITS) - 33'd1;

  rtmd_state_t state, state_next;

  // Drive state
  logic [TIME_BITS-1:0] elapsed_count;
  logic [TIME_BITS-1:0] time_limit;
  logic                 limited_run;
  logic                 run_flag;
  logic [RAMP_W-1:0]    ramp_length;
  logic [LEVEL_W-1:0]   target_level;
  logic                 line_a;
  logic                 line_b;
  logic [LEVEL_W-1:0]   duty_level;
  logic                 ended;

  // Decoded input fields
  logic                 in_kind;
  logic [DIR_W-1:0]     in_dir;
  logic [ONTIME_W-1:0]  in_on_time;
  logic [RAMP_W-1:0]    in_ramp;
  logic [LEVEL_W-1:0]   in_speed;

  logic                 accept;
  logic                 is_stop;
  logic [LEVEL_W-1:0]   in_target;
  logic [32:0]          in_limit_w;
  logic [TIME_BITS-1:0] in_limit;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic                 tick_end;
  logic                 ramp_full;
  logic                 need_div;
  logic                 mul_start;
  logic                 div_start;
  logic                 load_out;

  logic                 mul_done;
  logic [PROD_W-1:0]    product;
  logic                 div_done;
  logic [LEVEL_W-1:0]   quotient;

  // Unpack the input item
  assign in_kind    = s_tuser;
  assign in_dir     = s_tdata[1:0];
  assign in_on_time = s_tdata[26:2];
  assign in_ramp    = s_tdata[42:27];
  assign in_speed   = s_tdata[52:43];

  // Decode the command and the next tick
  always_comb begin
    is_stop    = (in_dir != DIR_FWD && in_dir != DIR_REV) || (in_on_time == '0);
    in_target  = (32'(in_speed) < DUTY_MAX) ? in_speed : LEVEL_W'(DUTY_MAX);
    in_limit_w = 33'(in_on_time[ONTIME_W-2:0]);
    in_limit   = TIME_BITS'((in_limit_w < TIME_MAX_W) ? in_limit_w : TIME_MAX_W);
    elapsed_inc = (elapsed_count == '1) ? elapsed_count : elapsed_count + 1'b1;
    tick_end   = limited_run && (elapsed_inc > time_limit);
    ramp_full  = (ramp_length == '0) || (elapsed_inc >= TIME_BITS'(ramp_length));
  end

  assign accept   = s_tvalid && s_tready;
  assign need_div = (in_kind == KIND_TICK) && run_flag && !tick_end && !ramp_full;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencing strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (need_div) begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Update drive state on each accepted item and on divider completion
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_count <= '0;
      time_limit    <= '0;
      limited_run   <= 1'b0;
      run_flag      <= 1'b0;
      ramp_length   <= '0;
      target_level  <= '0;
      line_a        <= 1'b0;
      line_b        <= 1'b0;
      duty_level    <= '0;
      ended         <= 1'b0;
    end else if (accept) begin
      ended <= 1'b0;
      if (in_kind == KIND_CMD) begin
        if (is_stop) begin
          duty_level  <= '0;
          line_a      <= 1'b0;
          line_b      <= 1'b0;
          run_flag    <= 1'b0;
          limited_run <= 1'b0;
        end else begin
          line_a        <= (in_dir == DIR_FWD);
          line_b        <= (in_dir == DIR_REV);
          elapsed_count <= '0;
          ramp_length   <= in_ramp;
          target_level  <= in_target;
          run_flag      <= 1'b1;
          limited_run   <= !in_on_time[ONTIME_W-1];
          if (!in_on_time[ONTIME_W-1]) begin
            time_limit <= in_limit;
          end
          duty_level <= (in_ramp == '0) ? in_target : '0;
        end
      end else if (run_flag) begin
        elapsed_count <= elapsed_inc;
        if (tick_end) begin
          duty_level  <= '0;
          line_a      <= 1'b0;
          line_b      <= 1'b0;
          run_flag    <= 1'b0;
          limited_run <= 1'b0;
          ended       <= 1'b1;
        end else if (ramp_full) begin
          duty_level <= target_level;
        end
      end
    end else if (div_done && state == ST_DIV) begin
      duty_level <= quotient;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {2'b00, ended, run_flag, line_b, line_a, duty_level};
    end
  end

  // Ramp product: elapsed is below the ramp length here
  rtmd_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (elapsed_inc[RAMP_W-1:0]),
    .mplier  (target_level),
    .done    (mul_done),
    .product (product)
  );

  // Ramp quotient: below the target level, so ten bits hold it
  rtmd_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (ramp_length),
    .done     (div_done),
    .quotient (quotient)
  );

  // Serial units finish only in their own sequencer state
  assert property (@(posedge clk) disable iff (rst) mul_done |-> state == ST_MUL)
    else $error("multiplier finished outside its step");

  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("divider finished outside its step");

  // A stopped bridge has zero duty and both lines low
  assert property (@(posedge clk) disable iff (rst)
    !run_flag |-> (duty_level == '0 && !line_a && !line_b))
    else $error("stopped bridge still driven");

  // Ramp duty never passes the target level
  assert property (@(posedge clk) disable iff (rst)
    run_flag |-> duty_level <= target_level)
    else $error("duty above target level");

endmodule

### hdl/rtmd_serial_mul.sv
// Bit-serial shift-add multiplier for the ramp product.
`timescale 1ns / 1ps

module rtmd_serial_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rtmd_pkg::RAMP_W-1:0]     mcand,
  input  logic [rtmd_pkg::LEVEL_W-1:0]    mplier,
  output logic                            done,
  output logic [rtmd_pkg::PROD_W-1:0]     product
);
  import rtmd_pkg::*;

  logic                 busy;
  logic [MUL_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    mcand_sh;
  logic [LEVEL_W-1:0]   mplier_sh;
  logic [PROD_W-1:0]    acc;

  // Control: run one multiplier bit per cycle, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_CNT_W'(LEVEL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add the shifted multiplicand when the low multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_sh  <= PROD_W'(mcand);
      mplier_sh <= mplier;
      acc       <= '0;
    end else if (busy) begin
      if (mplier_sh[0]) begin
        acc <= acc + mcand_sh;
      end
      mcand_sh  <= {mcand_sh[PROD_W-2:0], 1'b0};
      mplier_sh <= {1'b0, mplier_sh[LEVEL_W-1:1]};
    end
  end

  assign product = acc;

endmodule

### hdl/rtmd_serial_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp duty.
`timescale 1ns / 1ps

module rtmd_serial_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rtmd_pkg::PROD_W-1:0]     dividend,
  input  logic [rtmd_pkg::RAMP_W-1:0]     divisor,
  output logic                            done,
  output logic [rtmd_pkg::LEVEL_W-1:0]    quotient
);
  import rtmd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dvd_sh;
  logic [RAMP_W-1:0]    dvsr;
  logic [RAMP_W-1:0]    rem;
  logic [LEVEL_W-1:0]   quo;
  logic [RAMP_W:0]      trial;
  logic                 fits;

  // Bring down the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem, dvd_sh[PROD_W-1]};
    fits  = trial >= {1'b0, dvsr};
  end

  // Control: one step per dividend bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder stays below the divisor, so its width suffices
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_sh <= dividend;
      dvsr   <= divisor;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      dvd_sh <= {dvd_sh[PROD_W-2:0], 1'b0};
      rem    <= fits ? RAMP_W'(trial - {1'b0, dvsr}) : trial[RAMP_W-1:0];
      quo    <= {quo[LEVEL_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule
